>>> sv/imq_pkg.sv
`timescale 1ns / 1ps
// imq_pkg: field widths, constants and shared types of the intra macroblock quantiser
// no dependencies; every other file of the block imports it

package imq_pkg;

   localparam int COEFF_W     = 12;  // input coefficient, two's complement
   localparam int LEVEL_W     = 9;   // output level, two's complement
   localparam int PATTERN_W   = 6;   // coded block pattern
   localparam int QP_W        = 5;   // quantisation step
   localparam int QUO_W       = 11;  // AC quotient bits, magnitude halved
   localparam int DC_SHIFT    = 3;   // DC divisor is 8
   localparam int DC_W        = 8;   // DC level bits
   localparam int AC_W        = 7;   // saturated AC magnitude bits
   localparam int PATTERN_TOP = 5;   // pattern bit of block 0

   localparam logic [DC_W-1:0] DC_MIN = 8'd1;
   localparam logic [DC_W-1:0] DC_MAX = 8'd254;
   localparam logic [AC_W-1:0] AC_MAX = 7'd127;
   localparam logic [QP_W-1:0] QP_RESET = 5'd1;

   // register file: byte address 4*i, index taken from paddr above the byte offset
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] REG_QUANT_STEP = 1'b0;

   // position tracking towards the datapath
   typedef struct packed {
      logic                 is_dc;
      logic                 mb_last;
      logic [PATTERN_W-1:0] pattern;
   } imq_track_type;

endpackage

>>> sv/imq_if.sv
`timescale 1ns / 1ps
// imq_req_if / imq_rsp_if: valid-ready channels for coefficients and quantised levels
// depends on imq_pkg for the payload widths

interface imq_req_if;
   import imq_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [COEFF_W-1:0] coefficient;

   modport source (output valid, output coefficient, input ready);
   modport sink   (input valid, input coefficient, output ready);
endinterface

interface imq_rsp_if;
   import imq_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [LEVEL_W-1:0] level;
   logic                      mb_last;
   logic [PATTERN_W-1:0]      coded_pattern;

   modport source (output valid, output level, output mb_last, output coded_pattern,
                   input ready);
   modport sink   (input valid, input level, input mb_last, input coded_pattern,
                   output ready);
endinterface

>>> sv/imq_csr.sv
`timescale 1ns / 1ps
// imq_csr: APB-style register file holding the quantisation step
// depends on imq_pkg

module imq_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [imq_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [imq_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [imq_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready,
   output logic [imq_pkg::QP_W-1:0]          quant_step
);
   import imq_pkg::*;

   logic [QP_W-1:0]        qp_ff;
   logic [QP_W-1:0]        qp_in;
   logic [CSR_INDEX_W-1:0] index;
   logic                   hit;

   assign index = csr_paddr[CSR_ADDR_W-1:2];
   assign hit   = (index == REG_QUANT_STEP);

   always_comb begin
      qp_in = qp_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit) begin
         qp_in = csr_pwdata[QP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qp_ff <= QP_RESET;
      end else begin
         qp_ff <= qp_in;
      end
   end

   assign csr_prdata = hit ? {{(CSR_DATA_W-QP_W){1'b0}}, qp_ff} : '0;
   assign csr_pready = 1'b1;
   assign quant_step = qp_ff;

endmodule

>>> sv/imq_serial_div.sv
`timescale 1ns / 1ps
// imq_serial_div: restoring divider, one quotient bit per cycle, MSB first
// depends on imq_pkg

module imq_serial_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [imq_pkg::QUO_W-1:0]  dividend,
   input  logic [imq_pkg::QP_W-1:0]   divisor,
   output logic                       busy,
   output logic [imq_pkg::QUO_W-1:0]  quotient
);
   import imq_pkg::*;

   localparam int CNT_W = $clog2(QUO_W + 1);

   logic [QUO_W-1:0] work_ff, work_in;   // dividend bits out, quotient bits in
   logic [QP_W-1:0]  rem_ff, rem_in;
   logic [QP_W-1:0]  dsr_ff, dsr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [QP_W:0]    trial;
   logic [QP_W:0]    diff;
   logic             fits;

   assign trial = {rem_ff, work_ff[QUO_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = (trial >= {1'b0, dsr_ff});

   always_comb begin
      work_in = work_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         work_in = dividend;
         rem_in  = '0;
         // a zero step behaves as one
         dsr_in  = (divisor == '0) ? QP_W'(1) : divisor;
         cnt_in  = CNT_W'(QUO_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         work_in = {work_ff[QUO_W-2:0], fits};
         rem_in  = fits ? diff[QP_W-1:0] : trial[QP_W-1:0];
         cnt_in  = cnt_ff - CNT_W'(1);
         busy_in = (cnt_ff != CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   assign busy     = busy_ff;
   assign quotient = work_ff;

endmodule

>>> sv/imq_block_track.sv
`timescale 1ns / 1ps
// imq_block_track: coefficient and block counters, coded flags and block pattern
// depends on imq_pkg

module imq_block_track #(
   parameter int BLOCKS_PER_MB    = 6,
   parameter int COEFFS_PER_BLOCK = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    commit,
   input  logic                    ac_nonzero,
   output imq_pkg::imq_track_type  track
);
   import imq_pkg::*;

   localparam int POS_W = $clog2(COEFFS_PER_BLOCK);
   localparam int BLK_W = (BLOCKS_PER_MB > 1) ? $clog2(BLOCKS_PER_MB) : 1;

   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [BLK_W-1:0]     blk_ff, blk_in;
   logic                 nz_ff, nz_in;
   logic [PATTERN_W-1:0] pat_ff, pat_in;
   logic                 is_dc;
   logic                 end_block;
   logic                 end_mb;
   logic                 block_coded;
   logic [PATTERN_W-1:0] block_bit;
   logic [PATTERN_W-1:0] pat_closed;

   assign is_dc       = (pos_ff == '0);
   assign end_block   = (pos_ff == POS_W'(COEFFS_PER_BLOCK - 1));
   assign end_mb      = end_block && (blk_ff == BLK_W'(BLOCKS_PER_MB - 1));
   assign block_coded = nz_ff || (!is_dc && ac_nonzero);

   // blocks beyond the sixth own no pattern bit
   always_comb begin
      for (int i = 0; i < PATTERN_W; i++) begin
         block_bit[i] = (int'(blk_ff) == PATTERN_TOP - i);
      end
   end

   assign pat_closed = block_coded ? (pat_ff | block_bit) : pat_ff;

   always_comb begin
      pos_in = pos_ff;
      blk_in = blk_ff;
      nz_in  = nz_ff;
      pat_in = pat_ff;
      if (commit) begin
         if (end_block) begin
            pos_in = '0;
            nz_in  = 1'b0;
            if (end_mb) begin
               blk_in = '0;
               pat_in = '0;
            end else begin
               blk_in = blk_ff + BLK_W'(1);
               pat_in = pat_closed;
            end
         end else begin
            pos_in = pos_ff + POS_W'(1);
            nz_in  = block_coded;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         blk_ff <= '0;
         nz_ff  <= 1'b0;
         pat_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         blk_ff <= blk_in;
         nz_ff  <= nz_in;
         pat_ff <= pat_in;
      end
   end

   assign track.is_dc   = is_dc;
   assign track.mb_last = end_mb;
   assign track.pattern = end_mb ? pat_closed : '0;

endmodule

>>> sv/intra_macroblock_quantizer.sv
`timescale 1ns / 1ps
// channel   dir  handshake          payload
// req_chan  in   valid / ready      coefficient (12b signed)
// rsp_chan  out  valid / ready      level (9b signed), mb_last, coded_pattern (6b)
// csr_*     in   APB setup+access   quant_step at byte 0
//
// one coefficient at a time: accepting one starts the bit-serial divider, and the input
// reopens once its level has been loaded into the result register
// a finished level waits in the result register while the next coefficient divides
// a stalled result port holds the divided level until the register frees up
// synchronous active-high reset: counters, pattern, step = 1, no result pending
// depends on imq_pkg, imq_if, imq_csr, imq_serial_div, imq_block_track

module intra_macroblock_quantizer #(
   parameter int BLOCKS_PER_MB    = 6,
   parameter int COEFFS_PER_BLOCK = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   imq_req_if.sink                         req_chan,
   imq_rsp_if.source                       rsp_chan,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [imq_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [imq_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [imq_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import imq_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE
   } state_type;

   state_type             state_ff, state_in;
   logic                  neg_ff, neg_in;
   logic [DC_W-1:0]       dc_ff, dc_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0]    level_ff, level_in;
   logic                  last_ff, last_in;
   logic [PATTERN_W-1:0]  pattern_ff, pattern_in;

   logic [QP_W-1:0]       quant_step;
   logic                  accept;
   logic                  div_busy;
   logic [QUO_W-1:0]      quotient;
   logic [COEFF_W-1:0]    raw;
   logic [COEFF_W-1:0]    mag;
   logic [DC_W-1:0]       dc_div;
   logic [AC_W-1:0]       ac_mag;
   logic [LEVEL_W-1:0]    ac_level;
   logic                  ac_nonzero;
   logic                  slot_free;
   logic                  commit;
   imq_track_type         track;

   imq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .quant_step  (quant_step)
   );

   assign accept = req_chan.valid && req_chan.ready;
   assign raw    = req_chan.coefficient;
   assign mag    = raw[COEFF_W-1] ? (~raw + COEFF_W'(1)) : raw;

   // magnitude / (2*qp) == (magnitude >> 1) / qp
   imq_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .dividend (mag[COEFF_W-1:1]),
      .divisor  (quant_step),
      .busy     (div_busy),
      .quotient (quotient)
   );

   imq_block_track #(
      .BLOCKS_PER_MB    (BLOCKS_PER_MB),
      .COEFFS_PER_BLOCK (COEFFS_PER_BLOCK)
   ) u_track (
      .clock      (clock),
      .reset      (reset),
      .commit     (commit),
      .ac_nonzero (ac_nonzero),
      .track      (track)
   );

   // dc: positive value over 8, clamped; negative dc gives the minimum
   assign dc_div = raw[COEFF_W-2:DC_SHIFT];

   assign ac_mag     = (|quotient[QUO_W-1:AC_W]) ? AC_MAX : quotient[AC_W-1:0];
   assign ac_nonzero = (quotient != '0);
   assign ac_level   = neg_ff ? (LEVEL_W'(0) - LEVEL_W'(ac_mag)) : LEVEL_W'(ac_mag);

   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign commit    = (state_ff == ST_DIVIDE) && !div_busy && slot_free;

   always_comb begin
      state_in     = state_ff;
      neg_in       = neg_ff;
      dc_in        = dc_ff;
      rsp_valid_in = rsp_valid_ff;
      level_in     = level_ff;
      last_in      = last_ff;
      pattern_in   = pattern_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               neg_in = raw[COEFF_W-1];
               if (raw[COEFF_W-1] || dc_div == '0) begin
                  dc_in = DC_MIN;
               end else if (dc_div > DC_MAX) begin
                  dc_in = DC_MAX;
               end else begin
                  dc_in = dc_div;
               end
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (commit) begin
               rsp_valid_in = 1'b1;
               level_in     = track.is_dc ? LEVEL_W'(dc_ff) : ac_level;
               last_in      = track.mb_last;
               pattern_in   = track.pattern;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      neg_ff     <= neg_in;
      dc_ff      <= dc_in;
      level_ff   <= level_in;
      last_ff    <= last_in;
      pattern_ff <= pattern_in;
   end

   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.level        = level_ff;
   assign rsp_chan.mb_last      = last_ff;
   assign rsp_chan.coded_pattern = pattern_ff;

endmodule

>>> sv/imq_checker.sv
`timescale 1ns / 1ps
// imq_checker: port-level assertions for the intra macroblock quantiser, with its bind
// depends on imq_pkg and the top level intra_macroblock_quantizer

module imq_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [imq_pkg::LEVEL_W-1:0]  rsp_level,
   input logic                                rsp_mb_last,
   input logic [imq_pkg::PATTERN_W-1:0]       rsp_coded_pattern
);
   import imq_pkg::*;

   // a stalled result keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_level)
         && $stable(rsp_mb_last) && $stable(rsp_coded_pattern))
      else $error("result changed while stalled");

   // the pattern is only reported with the macroblock's last coefficient
   a_pattern_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_mb_last |-> rsp_coded_pattern == '0)
      else $error("coded pattern outside the last coefficient");

   // levels never fall below the negative AC saturation
   a_level_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_level >= -$signed(LEVEL_W'(AC_MAX)))
      else $error("level below saturation floor");

   // one coefficient at a time: a transfer closes the input until its level enters the result register
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input reopened right after a transfer");

endmodule

bind intra_macroblock_quantizer imq_checker u_imq_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_level         (rsp_chan.level),
   .rsp_mb_last       (rsp_chan.mb_last),
   .rsp_coded_pattern (rsp_chan.coded_pattern)
);

>>> test/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for intra_macroblock_quantizer, with its own level predictor
// depends on imq_pkg, imq_if and the quantiser top level with everything below it

module testbench;
   import imq_pkg::*;

   localparam int MB_BLOCKS     = 6;
   localparam int BLOCK_COEFFS  = 64;
   localparam int MB_COEFFS     = MB_BLOCKS * BLOCK_COEFFS;
   localparam int MB_TARGET     = 4;      // whole macroblocks in the run
   localparam int CALM_TAIL     = 200;    // final coefficients sent without idling
   localparam int WATCHDOG_MAX  = 2000;
   localparam int REPORT_MAX    = 10;
   localparam logic [CSR_ADDR_W-1:0] QUANT_STEP_ADDR = {REG_QUANT_STEP, 2'b00};

   typedef struct packed {
      logic signed [LEVEL_W-1:0] level;
      logic                      mb_last;
      logic [PATTERN_W-1:0]      coded_pattern;
   } level_item_type;

   typedef enum int {
      STYLE_ZERO, STYLE_LAST_ONLY, STYLE_SPARSE, STYLE_DENSE, STYLE_EDGES
   } block_style_type;

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   imq_req_if req_chan ();
   imq_rsp_if rsp_chan ();

   intra_macroblock_quantizer #(
      .BLOCKS_PER_MB    (MB_BLOCKS),
      .COEFFS_PER_BLOCK (BLOCK_COEFFS)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predictor state, kept alongside the block
   logic [QP_W-1:0] step_shadow;
   int              pos_shadow;
   int              block_shadow;
   logic            coded_shadow;
   logic [PATTERN_W-1:0] pattern_shadow;

   level_item_type  expected_levels[$];
   block_style_type block_style;
   bit           pacing_on;
   int           sent_count;
   int           levels_checked;
   int           macroblocks_seen;
   int           mismatches;
   int           idle_cycles;
   logic [31:0]  steps_written;

   initial clock = 1'b0;
   always #4 clock = ~clock;

   function automatic level_item_type quantise_coefficient(logic signed [COEFF_W-1:0] coeff);
      level_item_type item;
      int mag;
      int q;
      int divisor;
      mag = (coeff < 0) ? -int'(coeff) : int'(coeff);
      item = '0;
      if (pos_shadow == 0) begin
         if (coeff < 0) begin
            q = DC_MIN;
         end else begin
            q = mag >> DC_SHIFT;
            if (q < DC_MIN) q = DC_MIN;
            if (q > DC_MAX) q = DC_MAX;
         end
         item.level = LEVEL_W'(q);
      end else begin
         // a zero step behaves as a step of one
         divisor = 2 * ((step_shadow == 0) ? 1 : int'(step_shadow));
         q = mag / divisor;
         if (q > AC_MAX) q = AC_MAX;
         if (q != 0) coded_shadow = 1'b1;
         item.level = (coeff < 0) ? LEVEL_W'(-q) : LEVEL_W'(q);
      end
      if (pos_shadow == BLOCK_COEFFS - 1) begin
         if (coded_shadow && block_shadow <= PATTERN_TOP)
            pattern_shadow[PATTERN_TOP - block_shadow] = 1'b1;
         coded_shadow = 1'b0;
         pos_shadow = 0;
         if (block_shadow == MB_BLOCKS - 1) begin
            item.mb_last = 1'b1;
            item.coded_pattern = pattern_shadow;
            pattern_shadow = '0;
            block_shadow = 0;
         end else begin
            block_shadow++;
         end
      end else begin
         pos_shadow++;
      end
      return item;
   endfunction

   // result check first, then the prediction for a coefficient taken at the same edge
   always @(posedge clock) begin
      level_item_type want;
      level_item_type got;
      if (reset) begin
         step_shadow    <= QP_RESET;
         pos_shadow     = 0;
         block_shadow   = 0;
         coded_shadow   = 1'b0;
         pattern_shadow = '0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = '{rsp_chan.level, rsp_chan.mb_last, rsp_chan.coded_pattern};
            if (expected_levels.size() == 0) begin
               if (mismatches < REPORT_MAX)
                  $display("%0t: level %0d arrived with nothing outstanding", $realtime,
                           got.level);
               mismatches++;
            end else begin
               want = expected_levels.pop_front();
               levels_checked++;
               if (got.mb_last) macroblocks_seen++;
               if (got !== want) begin
                  if (mismatches < REPORT_MAX)
                     $display("%0t: level %0d last %0b cbp %b, expected %0d last %0b cbp %b",
                              $realtime, got.level, got.mb_last, got.coded_pattern,
                              want.level, want.mb_last, want.coded_pattern);
                  mismatches++;
               end
            end
         end
         if (req_chan.valid && req_chan.ready)
            expected_levels.push_back(quantise_coefficient(req_chan.coefficient));
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_psel && csr_penable))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_MAX) begin
         $display("watchdog: no transfer for %0d cycles, %0d levels outstanding",
                  idle_cycles, expected_levels.size());
         $display("FAILURE");
         $finish;
      end
   end

   // result side back-pressure in bursts
   initial begin
      rsp_chan.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (pacing_on && $urandom_range(0, 7) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   task automatic send_coefficient(input logic signed [COEFF_W-1:0] coeff);
      if (pacing_on && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.coefficient <= coeff;
      do @(posedge clock); while (!req_chan.ready);
      sent_count++;
   endtask

   task automatic wait_until_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (expected_levels.size() != 0) @(posedge clock);
   endtask

   // only called with the block idle
   task automatic write_quant_step(input logic [QP_W-1:0] step);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= QUANT_STEP_ADDR;
      csr_pwdata  <= {(CSR_DATA_W - QP_W)'($urandom()), step};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      step_shadow <= step;
      steps_written[step] = 1'b1;
   endtask

   function automatic logic signed [COEFF_W-1:0] pick_coefficient();
      int pos;
      int divisor;
      int v;
      pos = sent_count % BLOCK_COEFFS;
      divisor = 2 * ((step_shadow == 0) ? 1 : int'(step_shadow));
      v = int'($urandom_range(0, 4095)) - 2048;
      if (pos == 0) begin
         block_style = block_style_type'($urandom_range(STYLE_ZERO, STYLE_EDGES));
         case ($urandom_range(0, 7))
            0: v = -2048;
            1: v = -1;
            2: v = 0;
            3: v = 7;
            4: v = 8;
            5: v = 2032 + int'($urandom_range(0, 15));
            default: ;
         endcase
      end else begin
         case (block_style)
            STYLE_ZERO:
               v = int'($urandom_range(0, 2 * (divisor - 1))) - (divisor - 1);
            STYLE_LAST_ONLY:
               v = (pos != BLOCK_COEFFS - 1) ? 0 : ($urandom_range(0, 1) ? divisor : -divisor);
            STYLE_SPARSE:
               if ($urandom_range(0, 15) != 0) v = 0;
            STYLE_EDGES: begin
               case ($urandom_range(0, 4))
                  0: v = -2048;
                  1: v = 2047;
                  2: v = divisor;
                  3: v = divisor - 1;
                  default: v = divisor * (127 + int'($urandom_range(0, 1)));
               endcase
               if (v > 2047) v = 2047;
               if (v != -2048 && $urandom_range(0, 1)) v = -v;
            end
            default: ;
         endcase
      end
      return COEFF_W'(v);
   endfunction

   task automatic test_default_step_extremes();
      int coeffs[$] = '{2047, -2048, 2047, 0, 1, -1, 2, -2, 3, 254, 255, 256, -256};
      foreach (coeffs[i]) send_coefficient(COEFF_W'(coeffs[i]));
   endtask

   task automatic test_zero_step();
      int coeffs[$] = '{3, -3, 4, 2047};
      wait_until_drained();
      write_quant_step('0);
      foreach (coeffs[i]) send_coefficient(COEFF_W'(coeffs[i]));
   endtask

   // step change in the middle of a block
   task automatic test_mid_block_write();
      int coeffs[$] = '{61, 62, -62, -2048, 2047, 123, 124};
      wait_until_drained();
      write_quant_step(5'd31);
      foreach (coeffs[i]) send_coefficient(COEFF_W'(coeffs[i]));
   endtask

   task automatic test_random_macroblocks();
      int boundary;
      boundary = 0;
      while (sent_count < MB_TARGET * MB_COEFFS) begin
         if (sent_count % MB_COEFFS == 0 || $urandom_range(0, 199) == 0) begin
            wait_until_drained();
            case (boundary % 4)
               0: write_quant_step(5'd1);
               1: write_quant_step(5'd31);
               2: write_quant_step('0);
               default: write_quant_step(QP_W'($urandom_range(2, 30)));
            endcase
            boundary++;
         end
         if (sent_count >= MB_TARGET * MB_COEFFS - CALM_TAIL) pacing_on = 1'b0;
         send_coefficient(pick_coefficient());
      end
   endtask

   initial begin
      reset               = 1'b1;
      pacing_on           = 1'b1;
      sent_count          = 0;
      levels_checked      = 0;
      macroblocks_seen    = 0;
      mismatches          = 0;
      steps_written       = '0;
      req_chan.valid       <= 1'b0;
      req_chan.coefficient <= '0;
      csr_psel            <= 1'b0;
      csr_penable         <= 1'b0;
      csr_pwrite          <= 1'b0;
      csr_paddr           <= '0;
      csr_pwdata          <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_default_step_extremes();
      test_zero_step();
      test_mid_block_write();
      test_random_macroblocks();

      wait_until_drained();
      repeat (32) @(posedge clock);
      $display("%0d coefficients sent, %0d levels checked, %0d macroblocks with pattern",
               sent_count, levels_checked, macroblocks_seen);
      $display("%0d distinct quantiser steps written, %0d mismatches",
               $countones(steps_written), mismatches);
      if (mismatches == 0 && expected_levels.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> sim.f
sv/imq_pkg.sv
sv/imq_if.sv
sv/imq_csr.sv
sv/imq_serial_div.sv
sv/imq_block_track.sv
sv/intra_macroblock_quantizer.sv
sv/imq_checker.sv
test/testbench.sv
